[rtl/core/vtpg_pkg.sv]
`default_nettype none

package vtpg_pkg;

  localparam int COORD_LIMIT  = 4096;
  localparam int LABEL_LIMIT  = 20;
  localparam int COUNTER_BITS = 12;
  localparam int CNT_N        = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
  localparam int DIV_STEPS    = 8;
  localparam int BAR_STEPS    = 3;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PATTERN_MODE = 3'd2;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd3;
  localparam logic [2:0] REG_LABEL_COUNT  = 3'd4;
  localparam logic [2:0] REG_FRAME_INDEX  = 3'd5;

  localparam logic [2:0] MODE_FLAT   = 3'd0;
  localparam logic [2:0] MODE_GRAD   = 3'd1;
  localparam logic [2:0] MODE_BARS   = 3'd2;
  localparam logic [2:0] MODE_DETAIL = 3'd3;
  localparam logic [2:0] MODE_MARKER = 3'd4;

  localparam logic FMT_RGB888 = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  localparam logic [23:0] FLAT_RGB    = {8'd64, 8'd96, 8'd160};
  localparam logic [23:0] TALLY_RGB   = {8'd0, 8'd255, 8'd255};
  localparam logic [23:0] MAGENTA_RGB = {8'd255, 8'd0, 8'd255};
  localparam logic [23:0] RED_RGB     = {8'd255, 8'd0, 8'd0};

  // {r,g,b}
  function automatic logic [23:0] bar_colour(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = {8'd255, 8'd255, 8'd255};
      3'd1:    c = {8'd255, 8'd255, 8'd0};
      3'd2:    c = {8'd0, 8'd255, 8'd255};
      3'd3:    c = {8'd0, 8'd255, 8'd0};
      3'd4:    c = {8'd255, 8'd0, 8'd255};
      3'd5:    c = {8'd255, 8'd0, 8'd0};
      3'd6:    c = {8'd0, 8'd0, 8'd255};
      default: c = {8'd0, 8'd0, 8'd0};
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic        valid;
    logic [11:0] x;
    logic [11:0] y;
  } cap_t;

  typedef struct packed {
    logic        valid;
    logic        in_frame;
    logic [19:0] rrem;
    logic [19:0] grem;
    logic [7:0]  rq;
    logic [7:0]  gq;
    logic [14:0] brem;
    logic [2:0]  bq;
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic        bar_hit;
    logic        cnt_hit;
    logic        tally_hit;
  } pix_t;

endpackage

`default_nettype wire

[rtl/core/video_test_pattern_generator.sv]
// Test pattern generator: one pixel coordinate in, that pixel's framebuffer
// bytes out.
// Pixel channel: pix_valid/pix_stall with pixel_x, pixel_y. Result channel:
// rgb_valid/rgb_stall with byte0..byte2 and byte_count. A word moves at a
// clock edge where valid is high and stall is low.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
// while no pixel is in flight. cfg_ready is always high.
// Throughput: one pixel per cycle while pix_stall is low. A pixel passes the
// capture register, which loads on the accepting edge, then decode, the
// 8-step gradient divider pipeline (one quotient bit per stage) and the
// output register.
// After reset and after every config write, pix_stall is high while the
// moving-bar position is worked out by a bit-serial modulo unit (a load
// state, then 21 quotient steps).
// Reset restores the default registers (720x480, flat, RGB888) and empties
// the pipeline. When the receiver stalls, the whole pipeline holds and
// pix_stall rises the same cycle; no word is lost or repeated.
`default_nettype none

module video_test_pattern_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_valid,
  output logic             pix_stall,
  input  wire logic [11:0] pixel_x,
  input  wire logic [11:0] pixel_y,
  output logic             rgb_valid,
  input  wire logic        rgb_stall,
  output logic [7:0]       byte0,
  output logic [7:0]       byte1,
  output logic [7:0]       byte2,
  output logic [1:0]       byte_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import vtpg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [2:0]  pattern_mode;
  logic        pixel_format;
  logic [4:0]  label_count;
  logic [15:0] frame_index;

  logic [1:0]  state;
  logic [12:0] weff, heff;
  logic [11:0] wm1, hm1;
  logic        wide, tall;
  logic [4:0]  barw;
  logic [12:0] bar_mod;
  logic [20:0] mod_num;
  logic [12:0] mod_rem;
  logic [4:0]  mod_idx;
  logic [12:0] bx;
  logic signed [13:0] cnt_ylo;
  logic [12:0] cnt_yhi;
  logic [6:0]  lbl_cnt;

  logic [12:0] weff_next, heff_next;
  logic        wide_next, tall_next;
  logic [4:0]  barw_next;
  logic [13:0] rem_sh;
  logic [12:0] mod_rem_next;

  logic        en;
  logic        accept;
  cap_t        cap;
  pix_t        pipe [DIV_STEPS+1];
  pix_t        pipe_next [DIV_STEPS];
  pix_t        first_next;
  logic [7:0]  r, g, b;
  logic [15:0] v565;

  assign cfg_ready = 1'b1;
  assign en        = !(rgb_valid && rgb_stall);
  assign pix_stall = (state != ST_IDLE) || !en;
  assign accept    = pix_valid && !pix_stall;

  // derived geometry and the next modulo remainder
  always_comb begin
    if (frame_width < 13'd32) begin
      weff_next = 13'd32;
    end else if (14'(frame_width) > 14'(COORD_LIMIT)) begin
      weff_next = 13'(COORD_LIMIT);
    end else begin
      weff_next = frame_width;
    end
    if (frame_height < 13'd16) begin
      heff_next = 13'd16;
    end else if (14'(frame_height) > 14'(COORD_LIMIT)) begin
      heff_next = 13'(COORD_LIMIT);
    end else begin
      heff_next = frame_height;
    end
    wide_next = weff_next >= 13'd600;
    tall_next = heff_next >= 13'd240;
    barw_next = wide_next ? 5'd16 : 5'd8;
    rem_sh    = {mod_rem, mod_num[mod_idx]};
    if (rem_sh >= {1'b0, bar_mod}) begin
      mod_rem_next = 13'(rem_sh - {1'b0, bar_mod});
    end else begin
      mod_rem_next = rem_sh[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd720;
      frame_height <= 13'd480;
      pattern_mode <= MODE_FLAT;
      pixel_format <= FMT_RGB888;
      label_count  <= 5'd0;
      frame_index  <= 16'd0;
      state        <= ST_LOAD;
    end else if (cfg_valid) begin
      state <= ST_LOAD;
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_PATTERN_MODE: pattern_mode <= cfg_data[2:0];
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        REG_LABEL_COUNT:  label_count  <= cfg_data[4:0];
        REG_FRAME_INDEX:  frame_index  <= cfg_data;
        default: ;
      endcase
    end else begin
      unique case (state)
        ST_LOAD: begin
          weff    <= weff_next;
          heff    <= heff_next;
          wm1     <= 12'(weff_next - 13'd1);
          hm1     <= 12'(heff_next - 13'd1);
          wide    <= wide_next;
          tall    <= tall_next;
          barw    <= barw_next;
          bar_mod <= weff_next - 13'(barw_next);
          mod_num <= 21'(frame_index) * 21'(barw_next + 5'd4);
          mod_rem <= 13'd0;
          mod_idx <= 5'd20;
          cnt_ylo <= $signed({1'b0, heff_next}) - (tall_next ? 14'sd40 : 14'sd24);
          cnt_yhi <= heff_next - 13'd8;
          lbl_cnt <= (7'(label_count) > 7'(LABEL_LIMIT)) ? 7'(LABEL_LIMIT)
                                                         : 7'(label_count);
          state   <= ST_MOD;
        end
        ST_MOD: begin
          mod_rem <= mod_rem_next;
          if (mod_idx == 5'd0) begin
            bx    <= mod_rem_next;
            state <= ST_IDLE;
          end else begin
            mod_idx <= mod_idx - 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // decode stage: products, detail colours, overlay hits
  always_comb begin
    logic [13:0] x14, y14, lo;
    logic [7:0]  xl, yl;
    logic        y_cnt, y_tally;
    x14 = 14'(cap.x);
    y14 = 14'(cap.y);
    xl  = cap.x[7:0];
    yl  = cap.y[7:0];
    first_next.valid    = cap.valid;
    first_next.in_frame = (x14 < 14'(weff)) && (y14 < 14'(heff));
    first_next.rrem     = 20'({cap.x, 8'd0}) - 20'(cap.x);
    first_next.grem     = 20'({cap.y, 8'd0}) - 20'(cap.y);
    first_next.rq       = 8'd0;
    first_next.gq       = 8'd0;
    first_next.brem     = {cap.x, 3'd0};
    first_next.bq       = 3'd0;
    first_next.dr       = 8'(xl * 8'd7 + yl * 8'd3);
    first_next.dg       = 8'(xl * 8'd3 + yl * 8'd7);
    first_next.db       = 8'((xl ^ yl) * 8'd5);
    first_next.bar_hit  = (x14 >= 14'(bx)) && (x14 < 14'(bx) + 14'(barw));
    y_cnt = ($signed(y14) >= cnt_ylo) && (y14 < 14'(cnt_yhi));
    first_next.cnt_hit = 1'b0;
    for (int i = 0; i < CNT_N; i++) begin
      lo = wide ? 14'(8 + i * 40) : 14'(8 + i * 22);
      if (frame_index[i] && y_cnt && x14 >= lo &&
          x14 < lo + (wide ? 14'd32 : 14'd16)) begin
        first_next.cnt_hit = 1'b1;
      end
    end
    y_tally = (y14 >= 14'd6) && (y14 < (tall ? 14'd32 : 14'd18));
    first_next.tally_hit = 1'b0;
    for (int n = 0; n < LABEL_LIMIT; n++) begin
      lo = tall ? 14'(6 + n * 34) : 14'(6 + n * 20);
      if ((7'(n) < lbl_cnt) && y_tally && x14 >= lo &&
          x14 < lo + (tall ? 14'd26 : 14'd12)) begin
        first_next.tally_hit = 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    logic [19:0] rsh, gsh;
    logic [14:0] bsh;
    for (int i = 0; i < DIV_STEPS; i++) begin
      pipe_next[i] = pipe[i];
      rsh = 20'(wm1) << (DIV_STEPS - 1 - i);
      gsh = 20'(hm1) << (DIV_STEPS - 1 - i);
      if (pipe[i].rrem >= rsh) begin
        pipe_next[i].rrem = pipe[i].rrem - rsh;
        pipe_next[i].rq[DIV_STEPS-1-i] = 1'b1;
      end
      if (pipe[i].grem >= gsh) begin
        pipe_next[i].grem = pipe[i].grem - gsh;
        pipe_next[i].gq[DIV_STEPS-1-i] = 1'b1;
      end
    end
    for (int i = 0; i < BAR_STEPS; i++) begin
      bsh = 15'(weff) << (BAR_STEPS - 1 - i);
      if (pipe[i].brem >= bsh) begin
        pipe_next[i].brem = pipe[i].brem - bsh;
        pipe_next[i].bq[BAR_STEPS-1-i] = 1'b1;
      end
    end
  end

  // final colour
  always_comb begin
    logic [23:0] c;
    c = 24'd0;
    case (pattern_mode) inside
      MODE_FLAT:              c = FLAT_RGB;
      MODE_GRAD, MODE_MARKER: c = {pipe[DIV_STEPS].rq, pipe[DIV_STEPS].gq,
                                   (pattern_mode == MODE_MARKER) ? 8'd64 : 8'd128};
      MODE_BARS:              c = bar_colour(pipe[DIV_STEPS].bq);
      MODE_DETAIL:            c = {pipe[DIV_STEPS].dr, pipe[DIV_STEPS].dg,
                                   pipe[DIV_STEPS].db};
      default:                c = 24'd0;
    endcase
    if (pattern_mode == MODE_MARKER) begin
      if (pipe[DIV_STEPS].bar_hit) begin
        c = MAGENTA_RGB;
      end
      if (pipe[DIV_STEPS].cnt_hit) begin
        c = RED_RGB;
      end
    end
    if (pipe[DIV_STEPS].tally_hit) begin
      c = TALLY_RGB;
    end
    if (!pipe[DIV_STEPS].in_frame) begin
      c = 24'd0;
    end
    r    = c[23:16];
    g    = c[15:8];
    b    = c[7:0];
    v565 = {r[7:3], g[7:2], b[7:3]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap.valid <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) begin
        pipe[i].valid <= 1'b0;
      end
      rgb_valid <= 1'b0;
    end else if (en) begin
      cap.valid <= accept;
      cap.x     <= pixel_x;
      cap.y     <= pixel_y;
      pipe[0]   <= first_next;
      for (int i = 0; i < DIV_STEPS; i++) begin
        pipe[i+1] <= pipe_next[i];
      end
      rgb_valid <= pipe[DIV_STEPS].valid;
      if (pixel_format == FMT_RGB888) begin
        byte0      <= b;
        byte1      <= g;
        byte2      <= r;
        byte_count <= 2'd3;
      end else begin
        byte0      <= v565[7:0];
        byte1      <= v565[15:8];
        byte2      <= 8'd0;
        byte_count <= 2'd2;
      end
    end
  end

endmodule

`default_nettype wire
